[hw/rtl/adc_burst_average_to_millivolts_core_defines.svh]
// ----------------------------------------------------------------------------
// ADC burst averager assertion macros
// Shorthand for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef ADC_BURST_AVERAGE_TO_MILLIVOLTS_CORE_DEFINES_SVH
`define ADC_BURST_AVERAGE_TO_MILLIVOLTS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define ABAM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ABAM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/abam_pkg.sv]
// ----------------------------------------------------------------------------
// ADC burst averager package
// Shared types, codes, constants and small lookup functions.
// ----------------------------------------------------------------------------
package abam_pkg;

  // Operation codes of an input item
  localparam logic OP_START = 1'b0;
  localparam logic OP_CONV  = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_FINAL   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // Constants
  localparam int RefMv       = 600;
  localparam int CodeMax     = 16383;
  localparam int BurstCap    = 256;
  localparam int BurstCapLg  = $clog2(BurstCap);

  // Field widths
  localparam int ChW    = 3;
  localparam int CntW   = 16;
  localparam int ConvW  = 15;
  localparam int CodeW  = 14;
  localparam int LgW    = 4;
  localparam int MvW    = 12;
  localparam int SumW   = 30;
  localparam int ProdW  = MvW + CodeW;
  localparam int GainW  = 3;
  localparam int InDW   = 40;
  localparam int OutDW  = 24;

  // Mean divider widths
  localparam int DivNW  = SumW;
  localparam int DivDW  = CntW;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_SCALE,
    ST_MV,
    ST_PUSH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic decode;
    logic div_start;
    logic scale;
    logic take_mv;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic final_pend;
    logic div_done;
  } sts_t;

  // Exponent of the next burst: largest power of two not above r, capped
  function automatic logic [LgW-1:0] burst_log2(input logic [CntW-1:0] r);
    logic [LgW-1:0] lg;
    lg = '0;
    if (r[CntW-1:BurstCapLg] != '0) begin
      lg = LgW'(BurstCapLg);
    end else begin
      for (int i = 1; i < BurstCapLg; i++) begin
        if (r[i]) lg = LgW'(i);
      end
    end
    return lg;
  endfunction

  // Full scale in mV for each gain setting
  function automatic logic [MvW-1:0] full_scale(input logic [GainW-1:0] g);
    logic [MvW-1:0] fs;
    unique case (g)
      3'd0:    fs = MvW'(6 * RefMv);
      3'd1:    fs = MvW'(5 * RefMv);
      3'd2:    fs = MvW'(4 * RefMv);
      3'd3:    fs = MvW'(3 * RefMv);
      3'd4:    fs = MvW'(2 * RefMv);
      3'd5:    fs = MvW'(RefMv);
      3'd6:    fs = MvW'(RefMv / 2);
      default: fs = MvW'(RefMv / 4);
    endcase
    return fs;
  endfunction

endpackage

[hw/rtl/adc_burst_average_to_millivolts_core.sv]
// ----------------------------------------------------------------------------
// ADC burst averager core
// Plans oversampling bursts and turns their weighted mean into millivolts.
// ----------------------------------------------------------------------------
// Usage: a start transfer (tuser 0) carries channel and sample count; the
// core answers with a burst request. Each conversion transfer (tuser 1)
// is accumulated and answered with the next request, or after the last
// burst with the final millivolt value. Misuse gives an error result.
// Every input transfer produces exactly one output transfer.
// A request or error passes from the input latch through decode and the
// pending result registers to the output register; the final result also
// waits for the 30-step pass of the radix-2 divider for the mean, then is
// scaled and divided by the code range. The next input transfer is taken
// only after the previous result has been loaded into the output register.
// One item is in work at a time; in_tready is high only while idle, and
// the next item may be taken while the previous result still waits in
// the output register.
// Reset clears the measurement state and gain (gain 1/6, 3600 mV full
// scale). When out_tready is low the result holds and the core stops
// before it would overwrite the output register. gain_select is written
// through cfg_we / cfg_wdata by the user, only while idle; not enforced.
// ----------------------------------------------------------------------------
module adc_burst_average_to_millivolts_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [2:0] channel, [18:3] sample_count, [33:19] conversion, [39:34] zero
  input  logic [abam_pkg::InDW-1:0]  in_tdata,
  // [0] operation
  input  logic                       in_tuser,
  // Result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [2:0] request_channel, [6:3] oversample_log2, [7] burst_mode,
  // [19:8] millivolts, [23:20] zero
  output logic [abam_pkg::OutDW-1:0] out_tdata,
  // [1:0] kind
  output logic [1:0]                 out_tuser,
  // Configuration
  input  logic                       cfg_we,
  input  logic [abam_pkg::GainW-1:0] cfg_wdata
);
  import abam_pkg::*;

  cmd_t cmd;
  sts_t sts;

  abam_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  abam_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

[hw/rtl/abam_div.sv]
// ----------------------------------------------------------------------------
// ADC burst averager divider
// Restoring divider, one quotient bit per cycle, forms the measurement mean.
// ----------------------------------------------------------------------------
module abam_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [abam_pkg::DivNW-1:0] dividend,
  input  logic [abam_pkg::DivDW-1:0] divisor,
  output logic                      done,
  output logic [abam_pkg::DivNW-1:0] quotient
);
  import abam_pkg::*;

  localparam int CntW = $clog2(DivNW);
  localparam logic [CntW-1:0] LastStep = CntW'(DivNW - 1);

  logic [DivNW-1:0] quo_r, quo_nxt;
  logic [DivDW-1:0] rem_r, rem_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [DivDW-1:0] dvs_r;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [DivDW:0]   trial;
  logic [DivDW:0]   diff;

  // One restoring step
  assign trial = {rem_r, quo_r[DivNW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[DivDW]) begin
        rem_nxt = diff[DivDW-1:0];
        quo_nxt = {quo_r[DivNW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DivDW-1:0];
        quo_nxt = {quo_r[DivNW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LastStep) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/abam_datapath.sv]
// ----------------------------------------------------------------------------
// ADC burst averager datapath
// Input latch, measurement state, burst planning, scaling and result regs.
// ----------------------------------------------------------------------------
module abam_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [abam_pkg::InDW-1:0]  in_tdata,
  input  logic                       in_tuser,
  input  logic                       cfg_we,
  input  logic [abam_pkg::GainW-1:0] cfg_wdata,
  input  abam_pkg::cmd_t             cmd,
  output abam_pkg::sts_t             sts,
  output logic [abam_pkg::OutDW-1:0] out_tdata,
  output logic [1:0]                 out_tuser
);
  import abam_pkg::*;

  localparam logic [CodeW:0] CodeMaxF = (CodeW+1)'(CodeMax);

  // Latched input item
  logic             in_op_r;
  logic [ChW-1:0]   in_ch_r;
  logic [CntW-1:0]  in_cnt_r;
  logic [ConvW-1:0] in_conv_r;

  // Measurement state
  logic [GainW-1:0] gain_r;
  logic             busy_r, busy_nxt;
  logic [CntW-1:0]  remaining_r, remaining_nxt;
  logic [CntW-1:0]  total_r, total_nxt;
  logic [SumW-1:0]  sum_r, sum_nxt;
  logic [LgW-1:0]   lg_r, lg_nxt;
  logic [ChW-1:0]   chan_r, chan_nxt;

  // Pending result
  kind_t            res_kind_r, res_kind_nxt;
  logic [ChW-1:0]   res_ch_r, res_ch_nxt;
  logic [LgW-1:0]   res_lg_r, res_lg_nxt;
  logic             res_bm_r, res_bm_nxt;
  logic [MvW-1:0]   res_mv_r, res_mv_nxt;

  // Scaling and output
  logic [ProdW-1:0] prod_r;
  logic [OutDW-1:0] out_data_r;
  logic [1:0]       out_kind_r;

  // Division by the code range
  logic [MvW-1:0]   prod_hi;
  logic [CodeW-1:0] prod_lo;
  logic [CodeW:0]   fold;
  logic [MvW-1:0]   mv_quo;

  // Decode helpers
  logic [CodeW-1:0] conv_clamp;
  logic [SumW-1:0]  weighted;
  logic [CntW-1:0]  burst;
  logic [CntW-1:0]  rem_after;
  logic [LgW-1:0]   lg_start;
  logic [LgW-1:0]   lg_cont;
  logic             final_pend;

  // Divider
  logic [DivNW-1:0] div_dividend;
  logic [DivDW-1:0] div_divisor;
  logic [DivNW-1:0] div_quo;
  logic             div_done;

  // Negative codes count as zero; weight is a shift by the burst exponent
  assign conv_clamp = in_conv_r[ConvW-1] ? '0 : in_conv_r[CodeW-1:0];
  assign weighted   = {{(SumW-CodeW){1'b0}}, conv_clamp} << lg_r;
  assign burst      = {{(CntW-1){1'b0}}, 1'b1} << lg_r;
  assign rem_after  = remaining_r - burst;
  assign lg_start   = burst_log2(in_cnt_r);
  assign lg_cont    = burst_log2(rem_after);

  // Divide by 2^14 - 1: x = hi * 16383 + (hi + lo), with hi + lo below 2 * 16383
  assign prod_hi = prod_r[ProdW-1:CodeW];
  assign prod_lo = prod_r[CodeW-1:0];
  assign fold    = {{(CodeW+1-MvW){1'b0}}, prod_hi} + {1'b0, prod_lo};
  assign mv_quo  = prod_hi + {{(MvW-1){1'b0}}, (fold >= CodeMaxF)};

  // Item decode and state update
  always_comb begin
    busy_nxt      = busy_r;
    remaining_nxt = remaining_r;
    total_nxt     = total_r;
    sum_nxt       = sum_r;
    lg_nxt        = lg_r;
    chan_nxt      = chan_r;
    res_kind_nxt  = res_kind_r;
    res_ch_nxt    = res_ch_r;
    res_lg_nxt    = res_lg_r;
    res_bm_nxt    = res_bm_r;
    res_mv_nxt    = res_mv_r;
    final_pend    = 1'b0;
    if (cmd.decode) begin
      res_kind_nxt = KIND_ERROR;
      res_ch_nxt   = '0;
      res_lg_nxt   = '0;
      res_bm_nxt   = 1'b0;
      res_mv_nxt   = '0;
      if (in_op_r == OP_START) begin
        if (!busy_r && in_cnt_r != '0) begin
          busy_nxt      = 1'b1;
          chan_nxt      = in_ch_r;
          remaining_nxt = in_cnt_r;
          total_nxt     = in_cnt_r;
          sum_nxt       = '0;
          lg_nxt        = lg_start;
          res_kind_nxt  = KIND_REQUEST;
          res_ch_nxt    = in_ch_r;
          res_lg_nxt    = lg_start;
          res_bm_nxt    = (lg_start != '0);
        end
      end else if (busy_r) begin
        sum_nxt       = sum_r + weighted;
        remaining_nxt = rem_after;
        if (rem_after != '0) begin
          lg_nxt       = lg_cont;
          res_kind_nxt = KIND_REQUEST;
          res_ch_nxt   = chan_r;
          res_lg_nxt   = lg_cont;
          res_bm_nxt   = (lg_cont != '0);
        end else begin
          busy_nxt     = 1'b0;
          lg_nxt       = '0;
          final_pend   = 1'b1;
          res_kind_nxt = KIND_FINAL;
          res_ch_nxt   = chan_r;
        end
      end
    end
    if (cmd.take_mv) res_mv_nxt = mv_quo;
  end

  // Measurement state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= '0;
      busy_r      <= 1'b0;
      remaining_r <= '0;
      total_r     <= '0;
      sum_r       <= '0;
      lg_r        <= '0;
      chan_r      <= '0;
    end else begin
      if (cfg_we) gain_r <= cfg_wdata;
      busy_r      <= busy_nxt;
      remaining_r <= remaining_nxt;
      total_r     <= total_nxt;
      sum_r       <= sum_nxt;
      lg_r        <= lg_nxt;
      chan_r      <= chan_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_op_r   <= in_tuser;
      in_ch_r   <= in_tdata[ChW-1:0];
      in_cnt_r  <= in_tdata[ChW+CntW-1:ChW];
      in_conv_r <= in_tdata[ChW+CntW+ConvW-1:ChW+CntW];
    end
    res_kind_r <= res_kind_nxt;
    res_ch_r   <= res_ch_nxt;
    res_lg_r   <= res_lg_nxt;
    res_bm_r   <= res_bm_nxt;
    res_mv_r   <= res_mv_nxt;
    if (cmd.scale) begin
      prod_r <= ProdW'(full_scale(gain_r)) * ProdW'(div_quo[CodeW-1:0]);
    end
    if (cmd.load_out) begin
      out_data_r <= {{(OutDW-MvW-1-LgW-ChW){1'b0}}, res_mv_r, res_bm_r, res_lg_r, res_ch_r};
      out_kind_r <= res_kind_r;
    end
  end

  // Mean of the weighted sum over the sample count
  assign div_dividend = sum_r;
  assign div_divisor  = total_r;

  abam_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign sts.final_pend = final_pend;
  assign sts.div_done   = div_done;
  assign out_tdata      = out_data_r;
  assign out_tuser      = out_kind_r;

endmodule

[hw/rtl/abam_ctrl.sv]
// ----------------------------------------------------------------------------
// ADC burst averager controller
// Sequences decode, the mean divide, scaling and the result transfer.
// ----------------------------------------------------------------------------
module abam_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  abam_pkg::sts_t sts,
  output abam_pkg::cmd_t cmd
);
  import abam_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_tvalid) state_nxt = ST_DECODE;
      ST_DECODE:    state_nxt = sts.final_pend ? ST_MEAN_GO : ST_PUSH;
      ST_MEAN_GO:   state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (sts.div_done) state_nxt = ST_SCALE;
      ST_SCALE:     state_nxt = ST_MV;
      ST_MV:        state_nxt = ST_PUSH;
      ST_PUSH:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      ST_DECODE:  cmd.decode = 1'b1;
      ST_MEAN_GO: cmd.div_start = 1'b1;
      ST_SCALE:   cmd.scale = 1'b1;
      ST_MV:      cmd.take_mv = 1'b1;
      ST_PUSH:    cmd.load_out = out_free;
      default:    cmd = '0;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

[hw/rtl/abam_checker.sv]
// ----------------------------------------------------------------------------
// ADC burst averager port checker
// Checks on what the core's ports show over time, bound to the core.
// ----------------------------------------------------------------------------
`include "adc_burst_average_to_millivolts_core_defines.svh"

module abam_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [abam_pkg::OutDW-1:0] out_tdata,
  input logic [1:0]                 out_tuser
);
  import abam_pkg::*;

  // One item in work: no second transfer right after an accepted one
  `ABAM_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while busy")

  // Burst flag matches the exponent on requests
  `ABAM_ASSERT_SAME(a_burst_flag, clk, rst_n, out_tvalid && out_tuser == KIND_REQUEST, out_tdata[7] == (out_tdata[6:3] != 4'd0), "burst flag mismatch")

  // Burst exponent never exceeds the cap
  `ABAM_ASSERT_SAME(a_burst_cap, clk, rst_n, out_tvalid && out_tuser == KIND_REQUEST, out_tdata[6:3] <= 4'(BurstCapLg), "burst above cap")

  // Only a final result carries millivolts
  `ABAM_ASSERT_SAME(a_mv_final_only, clk, rst_n, out_tvalid && out_tuser != KIND_FINAL, out_tdata[19:8] == 12'd0, "millivolts on non-final")

  // A stalled result holds
  `ABAM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind adc_burst_average_to_millivolts_core abam_checker u_abam_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[bench/tb_adc_burst_average_to_millivolts_core.sv]
// ----------------------------------------------------------------------------
// Testbench for the ADC burst averager core
// Streams start and conversion items into the core under random source and
// sink gaps. A behavioral model plans the same bursts and computes the
// millivolt means. Every reply is checked field by field against that model,
// for all eight gain settings, with one long sink stall along the way.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_adc_burst_average_to_millivolts_core;
  import abam_pkg::*;

  // Full scale in mV per gain setting, setting 0 in the lowest bits
  localparam logic [95:0] FULL_SCALE_MV = {12'd150, 12'd300, 12'd600, 12'd1200,
                                           12'd1800, 12'd2400, 12'd3000, 12'd3600};
  // Gain written at the start of each random phase, phase 0 in the lowest bits
  localparam logic [23:0] GAIN_SEQ = {3'd5, 3'd2, 3'd4, 3'd1, 3'd6, 3'd3, 3'd0, 3'd7};
  localparam int unsigned CODE_RANGE = 16383;
  localparam int unsigned MAX_BURST  = 256;
  localparam int PHASE_ITEMS = 110;

  typedef struct {
    logic        op;
    logic [2:0]  ch;
    logic [15:0] cnt;
    logic [14:0] conv;
  } adc_item_t;

  typedef struct {
    kind_t       kind;
    logic [2:0]  ch;
    logic [3:0]  lg;
    logic        bm;
    logic [11:0] mv;
  } reply_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [InDW-1:0]      in_tdata  = '0;
  logic                 in_tuser  = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutDW-1:0]     out_tdata;
  logic [1:0]           out_tuser;
  logic                 cfg_we    = 1'b0;
  logic [GainW-1:0]     cfg_wdata = '0;

  // Stimulus and reply stores
  adc_item_t adc_item_q[$];
  reply_t    reply_q[$];
  int        items_queued = 0;
  int        n_in = 0, n_req = 0, n_fin = 0, n_err = 0, n_bad = 0;

  // Flow control
  bit        steady = 1'b0;       // no gaps on either side
  bit        squeeze_go = 1'b0;
  logic      hold_rx = 1'b0;
  int        tx_gap = 0, rx_gap = 0;

  // Model state
  bit          m_busy  = 1'b0;
  logic [15:0] m_left  = '0;
  logic [15:0] m_total = '0;
  logic [29:0] m_sum   = '0;
  logic [8:0]  m_burst = '0;
  logic [2:0]  m_ch    = '0;
  logic [2:0]  m_gain  = '0;

  adc_burst_average_to_millivolts_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Largest power of two not above rem, capped
  function automatic int unsigned burst_len(input int unsigned rem);
    int unsigned n;
    n = 1;
    while (n < MAX_BURST && (n << 1) <= rem) n = n << 1;
    return n;
  endfunction

  // Pick the next burst and build its request
  function automatic reply_t next_burst();
    reply_t      r;
    int unsigned n;
    n = burst_len(m_left);
    m_burst = n[8:0];
    r.kind = KIND_REQUEST;
    r.ch   = m_ch;
    r.lg   = 4'($clog2(n));
    r.bm   = (n > 1);
    r.mv   = '0;
    return r;
  endfunction

  // One accepted item through the averager model
  function automatic reply_t averager_step(input adc_item_t it);
    reply_t      r;
    logic [13:0] code;
    logic [15:0] n;
    int unsigned mean, fs, mv;
    r.kind = KIND_ERROR;
    r.ch   = '0;
    r.lg   = '0;
    r.bm   = 1'b0;
    r.mv   = '0;
    if (it.op == OP_START) begin
      if (m_busy || it.cnt == 0) return r;
      m_busy  = 1'b1;
      m_ch    = it.ch;
      m_left  = it.cnt;
      m_total = it.cnt;
      m_sum   = '0;
      r = next_burst();
    end else if (m_busy) begin
      // negative codes count as zero
      code = it.conv[14] ? 14'd0 : it.conv[13:0];
      n = 16'(m_burst);
      if (n == 0 || n > m_left) n = m_left;
      m_sum  = m_sum + code * n;
      m_left = m_left - n;
      if (m_left != 0) begin
        r = next_burst();
      end else begin
        mean = m_sum / m_total;
        fs   = FULL_SCALE_MV[m_gain*12 +: 12];
        mv   = fs * mean / CODE_RANGE;
        if (mv > 4095) mv = 4095;
        m_busy  = 1'b0;
        m_burst = '0;
        r.kind = KIND_FINAL;
        r.ch   = m_ch;
        r.mv   = mv[11:0];
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    if (steady || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_bad++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic queue_item(input logic op, input logic [2:0] ch, input logic [15:0] cnt,
                            input logic [14:0] conv);
    adc_item_t it;
    it.op   = op;
    it.ch   = ch;
    it.cnt  = cnt;
    it.conv = conv;
    adc_item_q.push_back(it);
    items_queued++;
  endtask

  // A full start-and-conversions sequence; noisy ones carry stray busy starts
  task automatic queue_measurement(input logic [2:0] ch, input logic [15:0] cnt,
                                   input bit all_max);
    int unsigned left;
    logic [14:0] conv;
    left = cnt;
    queue_item(OP_START, ch, cnt, all_max ? 15'd0 : 15'($urandom()));
    while (left > 0) begin
      left -= burst_len(left);
      if (!all_max && $urandom_range(0, 19) == 0)
        queue_item(OP_START, 3'($urandom()), 16'($urandom()), 15'($urandom()));
      if (all_max) begin
        conv = 15'h3FFF;
      end else begin
        case ($urandom_range(0, 9))
          0:       conv = 15'h3FFF;
          1:       conv = 15'h4000;
          2:       conv = 15'h7FFF;
          3:       conv = 15'($urandom());
          4:       conv = {1'b1, 14'($urandom())};
          default: conv = 15'($urandom_range(0, 16383));
        endcase
      end
      if (all_max) queue_item(OP_CONV, '0, '0, conv);
      else queue_item(OP_CONV, 3'($urandom()), 16'($urandom()), conv);
    end
  endtask

  // Wait until every item is in and every reply is out, then let the core settle
  task automatic drain_and_settle();
    do @(negedge clk);
    while (adc_item_q.size() != 0 || in_tvalid || reply_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Source: one item per transfer, random gap after each
  always @(posedge clk) begin : source
    adc_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) tx_gap = pick_gap();
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (adc_item_q.size() > 0) begin
          nxt = adc_item_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'd0, nxt.conv, nxt.cnt, nxt.ch};
          in_tuser  <= nxt.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink: random stall after each reply, plus the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_tvalid && out_tready) rx_gap = pick_gap();
      if (hold_rx) begin
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Long sink stall while the source keeps offering
  initial begin : rx_hold_off
    wait (squeeze_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Predict on each input transfer, check each output transfer
  always @(posedge clk) begin : watch
    adc_item_t it;
    reply_t    want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        it.op   = in_tuser;
        it.ch   = in_tdata[2:0];
        it.cnt  = in_tdata[18:3];
        it.conv = in_tdata[33:19];
        reply_q.push_back(averager_step(it));
        n_in++;
      end
      if (out_tvalid && out_tready) begin
        case (out_tuser)
          KIND_REQUEST: n_req++;
          KIND_FINAL:   n_fin++;
          default:      n_err++;
        endcase
        if (reply_q.size() == 0) begin
          report_mismatch("reply with nothing pending, kind", out_tuser, -1);
        end else begin
          want = reply_q.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch("kind", out_tuser, want.kind);
          if (out_tdata[2:0] !== want.ch)
            report_mismatch("request_channel", out_tdata[2:0], want.ch);
          if (out_tdata[6:3] !== want.lg)
            report_mismatch("oversample_log2", out_tdata[6:3], want.lg);
          if (out_tdata[7] !== want.bm)
            report_mismatch("burst_mode", out_tdata[7], want.bm);
          if (out_tdata[19:8] !== want.mv)
            report_mismatch("millivolts", out_tdata[19:8], want.mv);
          if (out_tdata[23:20] !== 4'd0)
            report_mismatch("tdata padding", out_tdata[23:20], 0);
        end
      end
    end
  end

  // Run limit
  initial begin
    #8000000;
    $display("tb_adc_burst_average_to_millivolts_core: FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    int           start_cnt;
    int           pick;
    logic [15:0]  cnt;
    logic [2:0]   g;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset gain
    queue_item(OP_CONV, 3'd4, 16'd9, 15'd100);      // conversion while idle
    queue_item(OP_START, 3'd3, 16'd0, 15'd0);       // zero count
    queue_item(OP_START, 3'd7, 16'd1, 15'd0);       // single sample
    queue_item(OP_CONV, 3'd0, 16'd0, 15'h3FFF);
    queue_item(OP_START, 3'd0, 16'd3, 15'd0);
    queue_item(OP_START, 3'd2, 16'd5, 15'd0);       // start while busy
    queue_item(OP_CONV, 3'd0, 16'd0, 15'h4000);     // most negative, counts as zero
    queue_item(OP_CONV, 3'd0, 16'd0, 15'h7FFF);
    queue_item(OP_START, 3'd5, 16'd257, 15'd0);     // capped burst then one
    queue_item(OP_CONV, 3'd0, 16'd0, 15'd8191);
    queue_item(OP_CONV, 3'd0, 16'd0, 15'd1);
    queue_item(OP_START, 3'd6, 16'd256, 15'd0);     // exactly the cap
    queue_item(OP_CONV, 3'd0, 16'd0, 15'h3FFF);
    queue_item(OP_START, 3'd1, 16'd255, 15'd0);     // every burst size below the cap
    for (int k = 0; k < 8; k++) queue_item(OP_CONV, '0, '0, 15'(k * 2047));
    queue_item(OP_CONV, 3'd7, 16'hFFFF, 15'h3FFF);  // idle again

    // Random phases, one gain setting each
    for (int p = 0; p < 8; p++) begin
      drain_and_settle();
      g = GAIN_SEQ[p*3 +: 3];
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= g;
      @(posedge clk);
      cfg_we <= 1'b0;
      m_gain = g;
      @(negedge clk);
      steady = (p == 3);
      if (p == 2) squeeze_go = 1'b1;
      // full count, full codes: largest sum at the extreme gains
      if (p < 2) queue_measurement(3'($urandom()), 16'hFFFF, 1'b1);
      start_cnt = items_queued;
      while (items_queued - start_cnt < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0: queue_item(OP_CONV, 3'($urandom()), 16'($urandom()), 15'($urandom()));
          1: queue_item(OP_START, 3'($urandom()), 16'd0, 15'($urandom()));
          default: begin
            pick = $urandom_range(0, 99);
            if (pick < 3) cnt = 16'($urandom_range(1, 65535));
            else if (pick < 15) cnt = 16'($urandom_range(1, 4095));
            else cnt = 16'($urandom_range(1, 600));
            queue_measurement(3'($urandom()), cnt, 1'b0);
          end
        endcase
      end
    end

    drain_and_settle();
    repeat (100) @(posedge clk);

    $display("covered %0d input transfers over all 8 gain settings, one 400-cycle sink stall",
             n_in);
    $display("replies: %0d burst requests, %0d measurements, %0d errors; %0d mismatches",
             n_req, n_fin, n_err, n_bad);
    if (n_bad == 0 && reply_q.size() == 0) begin
      $display("tb_adc_burst_average_to_millivolts_core: PASS");
    end else begin
      $display("tb_adc_burst_average_to_millivolts_core: FAIL");
    end
    $finish;
  end

endmodule
